@@ src/sle_pkg.sv @@
// sle_pkg: shared types and constants for the sorted list engine
// used by sle_ctrl, sle_datapath, sorted_list_engine_top and sle_checker
// no dependencies
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int RCNT_W   = 5;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_ELEMENT   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_REMOVE,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] dump_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [OCC_W-1:0]        occupancy;
    logic                    full;
    logic                    empty;
    logic                    hit;
    logic signed [VAL_W-1:0] elem;
  } dp_stat_t;

endpackage

@@ src/sle_datapath.sv @@
// sle_datapath: sorted entry row with parallel compare, shift insert and
// single-copy removal; depends on sle_pkg
module sle_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [sle_pkg::VAL_W-1:0] in_value,
  input  sle_pkg::dp_cmd_t                cmd,
  output sle_pkg::dp_stat_t               stat
);

  logic signed [sle_pkg::VAL_W-1:0] entries_r [sle_pkg::CAPACITY];
  logic signed [sle_pkg::VAL_W-1:0] value_r;
  logic [sle_pkg::OCC_W-1:0]        occ_r;
  logic [sle_pkg::OCC_W-1:0]        occ_nxt;

  logic [sle_pkg::CAPACITY-1:0] lt;
  logic [sle_pkg::CAPACITY-1:0] eq;
  logic [sle_pkg::OCC_W-1:0]    pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
      lt[i] = (sle_pkg::OCC_W'(i) < occ_r) && (entries_r[i] < value_r);
      eq[i] = (sle_pkg::OCC_W'(i) < occ_r) && (entries_r[i] == value_r);
      pos   = pos + sle_pkg::OCC_W'(lt[i]);
    end
  end

  always_comb begin
    stat.occupancy = occ_r;
    stat.full      = (occ_r == sle_pkg::OCC_W'(sle_pkg::CAPACITY));
    stat.empty     = (occ_r == '0);
    stat.hit       = |eq;
    stat.elem      = entries_r[cmd.dump_idx];
  end

  always_comb begin
    case (cmd.op)
      sle_pkg::OP_INSERT: occ_nxt = occ_r + 1'b1;
      sle_pkg::OP_REMOVE: occ_nxt = occ_r - 1'b1;
      sle_pkg::OP_CLEAR:  occ_nxt = '0;
      default:            occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sle_pkg::OP_LOAD) begin
      value_r <= in_value;
    end
  end

  // each cell takes its neighbour, the new word or keeps its own
  always_ff @(posedge clk) begin
    for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
      if (cmd.op == sle_pkg::OP_INSERT) begin
        if (sle_pkg::OCC_W'(i) == pos) begin
          entries_r[i] <= value_r;
        end else if (i > 0 && sle_pkg::OCC_W'(i) > pos) begin
          entries_r[i] <= entries_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.op == sle_pkg::OP_REMOVE) begin
        if (i < sle_pkg::CAPACITY - 1 && sle_pkg::OCC_W'(i) >= pos) begin
          entries_r[i] <= entries_r[(i < sle_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

endmodule

@@ src/sle_ctrl.sv @@
// sle_ctrl: action sequencer and registered result word
// depends on sle_pkg; drives sle_datapath through dp_cmd_t
module sle_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sle_pkg::ACT_W-1:0]        in_action,
  input  sle_pkg::dp_stat_t                stat,
  output sle_pkg::dp_cmd_t                 cmd,
  output logic                             out_strobe,
  output logic [sle_pkg::STAT_W-1:0]       out_status,
  output logic [sle_pkg::RCNT_W-1:0]       out_removed_count,
  output logic signed [sle_pkg::VAL_W-1:0] out_element,
  output logic                             out_last
);

  sle_pkg::state_t  state_r,  state_nxt;
  sle_pkg::action_t action_r, action_nxt;
  logic [sle_pkg::OCC_W-1:0] cnt_r, cnt_nxt;
  logic [sle_pkg::IDX_W-1:0] idx_r, idx_nxt;

  logic                             strobe_r, strobe_nxt;
  sle_pkg::status_t                 status_r, status_nxt;
  logic [sle_pkg::RCNT_W-1:0]       rcnt_r,   rcnt_nxt;
  logic signed [sle_pkg::VAL_W-1:0] elem_r,   elem_nxt;
  logic                             last_r,   last_nxt;

  logic dump_end;

  assign dump_end = ({1'b0, idx_r} == stat.occupancy - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sle_pkg::S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    rcnt_r   <= rcnt_nxt;
    elem_r   <= elem_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    action_nxt   = action_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    cmd.op       = sle_pkg::OP_NONE;
    cmd.dump_idx = idx_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    rcnt_nxt     = '0;
    elem_nxt     = '0;
    last_nxt     = 1'b1;
    case (state_r)
      sle_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = sle_pkg::OP_LOAD;
          action_nxt = sle_pkg::action_t'(in_action);
          state_nxt  = sle_pkg::S_DECIDE;
        end
      end
      sle_pkg::S_DECIDE: begin
        state_nxt = sle_pkg::S_IDLE;
        case (action_r)
          sle_pkg::ACT_INSERT: begin
            strobe_nxt = 1'b1;
            if (stat.full) begin
              status_nxt = sle_pkg::ST_FULL;
            end else begin
              cmd.op     = sle_pkg::OP_INSERT;
              status_nxt = sle_pkg::ST_INSERTED;
            end
          end
          sle_pkg::ACT_REMOVE: begin
            if (stat.empty) begin
              strobe_nxt = 1'b1;
              status_nxt = sle_pkg::ST_EMPTY;
            end else if (!stat.hit) begin
              strobe_nxt = 1'b1;
              status_nxt = sle_pkg::ST_NOT_FOUND;
            end else begin
              cmd.op    = sle_pkg::OP_REMOVE;
              cnt_nxt   = sle_pkg::OCC_W'(1);
              state_nxt = sle_pkg::S_REMOVE;
            end
          end
          sle_pkg::ACT_CLEAR: begin
            strobe_nxt = 1'b1;
            if (stat.empty) begin
              status_nxt = sle_pkg::ST_EMPTY;
            end else begin
              cmd.op     = sle_pkg::OP_CLEAR;
              status_nxt = sle_pkg::ST_CLEARED;
            end
          end
          default: begin
            if (stat.empty) begin
              strobe_nxt = 1'b1;
              status_nxt = sle_pkg::ST_EMPTY;
            end else begin
              idx_nxt   = '0;
              state_nxt = sle_pkg::S_DUMP;
            end
          end
        endcase
      end
      sle_pkg::S_REMOVE: begin
        // one copy leaves per cycle until no match remains
        if (stat.hit) begin
          cmd.op  = sle_pkg::OP_REMOVE;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = sle_pkg::ST_REMOVED;
          rcnt_nxt   = sle_pkg::RCNT_W'(cnt_r);
          state_nxt  = sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_DUMP: begin
        strobe_nxt = 1'b1;
        status_nxt = sle_pkg::ST_ELEMENT;
        elem_nxt   = stat.elem;
        last_nxt   = dump_end;
        idx_nxt    = idx_r + 1'b1;
        if (dump_end) begin
          state_nxt = sle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sle_pkg::S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != sle_pkg::S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_count = rcnt_r;
  assign out_element       = elem_r;
  assign out_last          = last_r;

endmodule

@@ src/sorted_list_engine_top.sv @@
// sorted_list_engine_top: bounded sorted multiset of signed 32-bit words
// depends on sle_pkg, sle_ctrl and sle_datapath
//
// Usage:
//   An input word (in_action, in_value) is taken on a rising edge with
//   start high and busy low. Actions: insert, remove all copies, clear,
//   dump in ascending order.
//   Each result word is shown for one cycle with out_strobe high; the
//   receiver must take it then, it cannot stall the block.
//   After acceptance the word is loaded, then the decide state sets the
//   result of insert, clear and every empty or not-found case; remove
//   then takes out one copy at a time until no match remains, and dump
//   shows one element per cycle, out_last on the final one. busy drops
//   in the cycle the final result is shown, so the next word can be taken
//   then. The removal loop and the one-element-per-cycle read port of the
//   entry row set how long remove and dump keep busy high.
//   Reset (rst_n low, synchronous) empties the store and drops out_strobe;
//   no clearing pass is needed.
module sorted_list_engine_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sle_pkg::ACT_W-1:0]        in_action,
  input  logic signed [sle_pkg::VAL_W-1:0] in_value,
  output logic                             out_strobe,
  output logic [sle_pkg::STAT_W-1:0]       out_status,
  output logic [sle_pkg::RCNT_W-1:0]       out_removed_count,
  output logic signed [sle_pkg::VAL_W-1:0] out_element,
  output logic                             out_last
);

  sle_pkg::dp_cmd_t  cmd;
  sle_pkg::dp_stat_t stat;

  sle_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .stat              (stat),
    .cmd               (cmd),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_element       (out_element),
    .out_last          (out_last)
  );

  sle_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_value),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

@@ src/sle_checker.sv @@
// sle_checker: port-level checks for sorted_list_engine_top
// depends on sle_pkg; attached to the top level by bind
module sle_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_strobe,
  input logic [sle_pkg::STAT_W-1:0]       out_status,
  input logic [sle_pkg::RCNT_W-1:0]       out_removed_count,
  input logic                             out_last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last == !busy))
    else $error("busy out of step with final result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != sle_pkg::ST_ELEMENT |-> out_last)
    else $error("single result without last flag");

  a_removed_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == sle_pkg::ST_REMOVED |-> out_removed_count != '0)
    else $error("removed status with zero count");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

endmodule

bind sorted_list_engine_top sle_checker u_sle_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_removed_count (out_removed_count),
  .out_last          (out_last)
);
